@@ hdl/length_framed_serial_deframer_unit_defines.svh @@
// ============================================================================
// Length-framed serial deframer assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ============================================================================
`ifndef LENGTH_FRAMED_SERIAL_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_FRAMED_SERIAL_DEFRAMER_UNIT_DEFINES_SVH

// Assertion that is switched off while reset is applied.
`define LFSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is applied.
`define LFSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/lfsd_pkg.sv @@
// ============================================================================
// Length-framed serial deframer package
// Shared types and constants of the deframer modules.
// ============================================================================
package lfsd_pkg;

    localparam logic [7:0]  C_START_BYTE   = 8'h73;
    localparam logic [7:0]  C_STORED_MARK  = 8'hFF;
    localparam logic [15:0] C_TIMEOUT_RST  = 16'd1000;
    localparam logic [15:0] C_ELAPSED_MAX  = 16'hFFFF;
    localparam logic        C_FUNC_BYTE    = 1'b0;
    localparam logic        C_FUNC_TICK    = 1'b1;

    // One input item: a received byte or a millisecond tick.
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_item;

    // One result item: a payload byte and, on the last byte, the header.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last_byte;
        logic       stored_call;
        logic [7:0] request_code;
        logic       write_access;
    } t_result;

    // Frame parser state.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LENGTH,
        ST_PAYLOAD
    } t_state;

endpackage

@@ hdl/length_framed_serial_deframer_unit.sv @@
// ============================================================================
// Length-framed serial deframer
// Parses 's', length, payload frames from serial bytes and millisecond ticks.
// ============================================================================
//
// Channel   Direction  Handshake                  Carries
// in        input      i_in_valid / o_in_ready    i_func, i_rx_byte
// out       output     o_out_valid / i_out_ready  payload byte, index, header
// cfg       input      i_cfg_we                   i_cfg_wdata (timeout_ms)
//
// An item is parsed straight out of the input register once the result
// register has room, and its result is held in the result register.
// One item is accepted per cycle while the output does not stall.
// A stall on the output holds the result register and then the input
// register; the input stays ready while the input register is empty.
// Reset is synchronous and active low; timeout_ms resets to 1000.
//
module length_framed_serial_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_byte_index,
    output logic        o_last_byte,
    output logic        o_stored_call,
    output logic [7:0]  o_request_code,
    output logic        o_write_access,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import lfsd_pkg::*;

    // Timeout register; the user must write it only while the parser is idle, the block does not enforce this.
    logic [15:0] r_timeout;

    t_item   in_item;
    t_item   s1_item;
    t_result core_result;
    t_result out_result;
    logic    step;
    logic    out_free;
    logic    res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= C_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    assign in_item.func    = i_func;
    assign in_item.rx_byte = i_rx_byte;

    // Input register: the item waits here until the parser consumes it.
    lfsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_drain (out_free),
        .o_step  (step),
        .o_item  (s1_item)
    );

    // The parser advances on every item; only payload bytes give a result.
    lfsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (s1_item),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .o_result    (core_result)
    );

    // Result register: it parts the output handshake from the parser.
    lfsd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_payload_byte = out_result.payload_byte;
    assign o_byte_index   = out_result.byte_index;
    assign o_last_byte    = out_result.last_byte;
    assign o_stored_call  = out_result.stored_call;
    assign o_request_code = out_result.request_code;
    assign o_write_access = out_result.write_access;

endmodule

@@ hdl/lfsd_in_reg.sv @@
// ============================================================================
// Deframer input register
// Holds one accepted input item until the parser consumes it.
// ============================================================================
module lfsd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lfsd_pkg::t_item i_item,
    input  logic            i_drain,
    output logic            o_step,
    output lfsd_pkg::t_item o_item
);
    import lfsd_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // The item is consumed whenever the stage behind has room.
    assign o_step  = r_valid && i_drain;
    assign o_ready = !r_valid || i_drain;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (o_step) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hdl/lfsd_core.sv @@
// ============================================================================
// Deframer parser core
// Frame state, elapsed-time counter and header decode for one item a cycle whenever one is stepped in.
// ============================================================================
module lfsd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  lfsd_pkg::t_item   i_item,
    input  logic [15:0]       i_timeout,
    output logic              o_res_valid,
    output lfsd_pkg::t_result o_result
);
    import lfsd_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_remaining;
    logic [7:0] n_remaining;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [15:0] r_elapsed;
    logic [15:0] n_elapsed;
    logic [7:0] r_hdr_first;
    logic [7:0] n_hdr_first;
    logic [7:0] r_hdr_second;
    logic [7:0] n_hdr_second;

    logic       is_byte;
    logic       timed_out;
    t_state     eff_state;
    logic [7:0] ch;
    logic [7:0] rem_dec;
    logic       last;
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;

    assign ch        = i_item.rx_byte;
    assign is_byte   = i_step && (i_item.func == C_FUNC_BYTE);
    // A partial frame that has waited too long is dropped before the byte.
    assign timed_out = (r_state != ST_IDLE) && (r_elapsed > i_timeout);
    assign eff_state = timed_out ? ST_IDLE : r_state;
    assign rem_dec   = r_remaining - 8'd1;
    assign last      = (rem_dec == 8'd0);
    assign hdr_first  = (r_count == 8'd0) ? ch : r_hdr_first;
    assign hdr_second = (r_count == 8'd1) ? ch : r_hdr_second;

    // Next state.
    always_comb begin
        n_state = r_state;
        if (is_byte) begin
            unique case (eff_state)
                ST_IDLE: begin
                    n_state = (ch == C_START_BYTE) ? ST_LENGTH : ST_IDLE;
                end
                ST_LENGTH: begin
                    n_state = (ch == 8'd0) ? ST_IDLE : ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    n_state = last ? ST_IDLE : ST_PAYLOAD;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    // Result of the current item.
    always_comb begin
        o_res_valid            = is_byte && (eff_state == ST_PAYLOAD);
        o_result.payload_byte  = ch;
        o_result.byte_index    = r_count;
        o_result.last_byte     = last;
        o_result.stored_call   = 1'b0;
        o_result.request_code  = 8'd0;
        o_result.write_access  = 1'b0;
        if (last) begin
            if (hdr_first == C_STORED_MARK) begin
                o_result.stored_call  = 1'b1;
                // A one-byte stored call has no code byte.
                o_result.request_code = (r_count != 8'd0) ? hdr_second : 8'd0;
            end else begin
                o_result.request_code = {1'b0, hdr_first[7:1]};
                o_result.write_access = hdr_first[0];
            end
        end
    end

    // Counters and header bytes.
    always_comb begin
        n_remaining  = r_remaining;
        n_count      = r_count;
        n_elapsed    = r_elapsed;
        n_hdr_first  = r_hdr_first;
        n_hdr_second = r_hdr_second;
        if (i_step && (i_item.func == C_FUNC_TICK)) begin
            if (r_elapsed != C_ELAPSED_MAX) begin
                n_elapsed = r_elapsed + 16'd1;
            end
        end else if (is_byte) begin
            unique case (eff_state)
                ST_IDLE: begin
                    if (ch == C_START_BYTE) begin
                        n_remaining = 8'd0;
                        n_count     = 8'd0;
                        n_elapsed   = 16'd0;
                    end
                end
                ST_LENGTH: begin
                    if (ch != 8'd0) begin
                        n_remaining = ch;
                        n_elapsed   = 16'd0;
                    end
                end
                ST_PAYLOAD: begin
                    n_hdr_first  = hdr_first;
                    n_hdr_second = hdr_second;
                    if (last) begin
                        n_remaining = 8'd0;
                        n_count     = 8'd0;
                    end else begin
                        n_remaining = rem_dec;
                        n_count     = r_count + 8'd1;
                        n_elapsed   = 16'd0;
                    end
                end
                default: begin
                    n_remaining = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_remaining  <= 8'd0;
            r_count      <= 8'd0;
            r_elapsed    <= 16'd0;
            r_hdr_first  <= 8'd0;
            r_hdr_second <= 8'd0;
        end else begin
            r_state      <= n_state;
            r_remaining  <= n_remaining;
            r_count      <= n_count;
            r_elapsed    <= n_elapsed;
            r_hdr_first  <= n_hdr_first;
            r_hdr_second <= n_hdr_second;
        end
    end

endmodule

@@ hdl/lfsd_out_reg.sv @@
// ============================================================================
// Deframer result register
// Holds one result item until the downstream side takes it.
// ============================================================================
module lfsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lfsd_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output lfsd_pkg::t_result o_result
);
    import lfsd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hdl/lfsd_checker.sv @@
// ============================================================================
// Deframer port checker
// Watches the top-level ports of the deframer and flags illegal behavior.
// ============================================================================
`include "length_framed_serial_deframer_unit_defines.svh"

module lfsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_byte_index,
    input logic        o_last_byte,
    input logic        o_stored_call,
    input logic [7:0]  o_request_code,
    input logic        o_write_access
);

    // A stalled result keeps its payload.
    `LFSD_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_byte_index) && $stable(o_last_byte),
        "stalled result changed")

    // Header fields are only set on the last payload byte.
    `LFSD_ASSERT(a_hdr_last_only, i_clk, i_rst_n,
        o_out_valid && !o_last_byte |->
            !o_stored_call && !o_write_access && (o_request_code == 8'd0),
        "header outside last byte")

    // A stored call never carries a write flag.
    `LFSD_ASSERT(a_stored_no_write, i_clk, i_rst_n,
        o_out_valid && o_stored_call |-> !o_write_access,
        "stored call with write flag")

    // No result is offered in the cycle after reset.
    `LFSD_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out_valid,
        "result valid after reset")

endmodule

bind length_framed_serial_deframer_unit lfsd_checker u_lfsd_checker (.*);

@@ tb/deframe_check_pkg.sv @@
// ============================================================================
// Deframer scoreboard
// Predicts the deframer results from accepted items and checks the results.
// ============================================================================
package deframe_check_pkg;

    import lfsd_pkg::*;

    class deframe_scoreboard;

        // Mirror of the parser state and of the timeout register.
        logic [15:0] timeout_ms_q = C_TIMEOUT_RST;
        logic        busy         = 1'b0;
        logic        have_length  = 1'b0;
        logic [7:0]  remaining    = '0;
        logic [7:0]  rx_count     = '0;
        logic [15:0] elapsed      = '0;
        logic [7:0]  first_byte   = '0;
        logic [7:0]  second_byte  = '0;

        t_result     pending_results[$];

        int unsigned mismatches       = 0;
        int unsigned results_seen     = 0;
        int unsigned frames_closed    = 0;
        int unsigned stored_calls     = 0;
        int unsigned frames_timed_out = 0;

        function void set_timeout(input logic [15:0] value);
            timeout_ms_q = value;
        endfunction

        function void abandon_frame();
            busy        = 1'b0;
            have_length = 1'b0;
            remaining   = '0;
            rx_count    = '0;
        endfunction

        // Advances the mirror by one accepted item and queues its result, if any.
        function void take_item(input logic func, input logic [7:0] data);
            t_result    res;
            logic [7:0] idx;
            if (func == C_FUNC_TICK) begin
                if (elapsed != C_ELAPSED_MAX)
                    elapsed++;
                return;
            end
            if (busy && elapsed > timeout_ms_q) begin
                abandon_frame();
                frames_timed_out++;
            end
            if (!busy) begin
                if (data == C_START_BYTE) begin
                    busy        = 1'b1;
                    have_length = 1'b0;
                    remaining   = '0;
                    rx_count    = '0;
                    elapsed     = '0;
                end
                return;
            end
            if (!have_length) begin
                if (data == 8'h00) begin
                    abandon_frame();
                end else begin
                    remaining   = data;
                    have_length = 1'b1;
                    elapsed     = '0;
                end
                return;
            end
            idx = rx_count;
            if (idx == 8'd0)
                first_byte = data;
            else if (idx == 8'd1)
                second_byte = data;
            rx_count++;
            remaining--;
            res              = '0;
            res.payload_byte = data;
            res.byte_index   = idx;
            res.last_byte    = (remaining == 8'd0);
            if (res.last_byte) begin
                if (first_byte == C_STORED_MARK) begin
                    res.stored_call  = 1'b1;
                    res.request_code = (idx >= 8'd1) ? second_byte : 8'h00;
                    stored_calls++;
                end else begin
                    res.request_code = first_byte >> 1;
                    res.write_access = first_byte[0];
                end
                frames_closed++;
                abandon_frame();
            end else begin
                elapsed = '0;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result byte=%02h index=%0d last=%0b",
                             got.payload_byte, got.byte_index, got.last_byte);
                return;
            end
            want = pending_results.pop_front();
            if (got.payload_byte !== want.payload_byte || got.byte_index !== want.byte_index ||
                got.last_byte !== want.last_byte || got.stored_call !== want.stored_call ||
                got.request_code !== want.request_code ||
                got.write_access !== want.write_access) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected byte=%02h index=%0d last=%0b stored=%0b code=%02h wr=%0b",
                             want.payload_byte, want.byte_index, want.last_byte,
                             want.stored_call, want.request_code, want.write_access);
                    $display("       actual   byte=%02h index=%0d last=%0b stored=%0b code=%02h wr=%0b",
                             got.payload_byte, got.byte_index, got.last_byte,
                             got.stored_call, got.request_code, got.write_access);
                end
            end
        endfunction

    endclass

endpackage

@@ tb/tb_top.sv @@
// ============================================================================
// Length-framed serial deframer testbench
// Drives bytes and millisecond ticks with random idling on both channels,
// predicts every payload result and checks each one as it is transferred.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lfsd_pkg::*;
    import deframe_check_pkg::*;

    // Cycles without any transfer before the run is declared hung. The longest
    // legal quiet stretch is the deliberate receiver hold.
    localparam int STALL_LIMIT  = 2000;
    // Cycles allowed for items that produce no result to leave the pipeline.
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_func;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_byte_index;
    logic        o_last_byte;
    logic        o_stored_call;
    logic [7:0]  o_request_code;
    logic        o_write_access;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    deframe_scoreboard sb;

    // Idle rates in percent, and a request for one long receiver hold.
    int unsigned tx_gap_pct       = 6;
    int unsigned rx_stall_pct     = 57;
    int          hold_request     = 0;
    int unsigned items_sent       = 0;
    int unsigned timeout_settings = 0;
    int unsigned quiet_cycles     = 0;

    length_framed_serial_deframer_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte),
        .o_stored_call  (o_stored_call),
        .o_request_code (o_request_code),
        .o_write_access (o_write_access),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver. Every cycle it decides afresh whether to take a result, except
    // when a long hold is requested: then ready stays low for the whole hold,
    // counted here, so the block backs up and has to stall its input.
    initial begin
        int hold_left;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
                repeat (hold_left) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Result monitor. Values are read right after the edge, before any
    // nonblocking update, so they are the ones the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_payload_byte, o_byte_index, o_last_byte,
                             o_stored_call, o_request_code, o_write_access});
    end

    // Watchdog on cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
                $display("length_framed_serial_deframer_unit test failed");
                $finish;
            end
        end
    end

    // Offers one item and waits for its transfer. A random gap before the
    // item drops valid; otherwise valid simply stays high from the last item.
    task automatic send_item(input logic func, input logic [7:0] data);
        int gap;
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_rx_byte  <= data;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_item(func, data);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(C_FUNC_BYTE, data);
    endtask

    // Tick items carry a random byte, which the block has to ignore.
    task automatic send_ticks(input int count);
        repeat (count) send_item(C_FUNC_TICK, 8'($urandom_range(255)));
    endtask

    // A quarter of the byte gaps get some ticks; gap_max near the timeout
    // makes some of those gaps long enough to drop the frame.
    task automatic maybe_ticks(input int gap_max);
        if ($urandom_range(3) == 0)
            send_ticks($urandom_range(0, gap_max));
    endtask

    // The timeout register is only written with the block idle: all expected
    // results have been transferred and trailing ticks have drained.
    task automatic set_timeout(input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_timeout(value);
        timeout_settings++;
    endtask

    // A complete frame with random content. The first payload byte is often
    // the stored-call mark, and now and then a payload byte is the start byte.
    task automatic send_frame(input int len, input int gap_max);
        logic [7:0] data;
        send_byte(C_START_BYTE);
        maybe_ticks(gap_max);
        send_byte(8'(len));
        for (int k = 0; k < len; k++) begin
            maybe_ticks(gap_max);
            if (k == 0 && $urandom_range(9) < 3)
                data = C_STORED_MARK;
            else if ($urandom_range(99) < 8)
                data = C_START_BYTE;
            else
                data = 8'($urandom_range(255));
            send_byte(data);
        end
    endtask

    // Mostly well-formed frames; the rest is stray bytes, zero lengths,
    // frames cut short and left to time out, and bursts of ticks.
    task automatic run_random(input int unsigned n_items);
        int unsigned stop_at;
        int          pick;
        int          len;
        int          gap_max;
        stop_at = items_sent + n_items;
        gap_max = (sb.timeout_ms_q <= 16) ? int'(sb.timeout_ms_q) + 2 : 3;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(49) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            if (pick < 72) begin
                send_frame(len, gap_max);
            end else if (pick < 80) begin
                send_byte(8'($urandom_range(255)));
            end else if (pick < 85) begin
                send_byte(C_START_BYTE);
                send_byte(8'h00);
            end else if (pick < 94) begin
                send_byte(C_START_BYTE);
                send_byte(8'(len + 1));
                repeat ($urandom_range(0, len)) send_byte(8'($urandom_range(255)));
                if (sb.timeout_ms_q <= 16)
                    send_ticks(int'(sb.timeout_ms_q) + 1 + $urandom_range(0, 2));
            end else begin
                send_ticks($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_func      <= C_FUNC_BYTE;
        i_rx_byte   <= 8'h00;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 16'h0000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset timeout. Sender idles rarely and the
        // receiver often in this first phase.
        send_byte(C_START_BYTE);            // shortest frame, all-zero payload
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(C_START_BYTE);            // stored call with its code byte
        send_byte(8'd2);
        send_byte(C_STORED_MARK);
        send_byte(8'hAB);
        send_byte(C_START_BYTE);            // stored call cut to one byte
        send_byte(8'd1);
        send_byte(C_STORED_MARK);
        send_byte(C_START_BYTE);            // zero length goes back to idle
        send_byte(8'd0);
        send_byte(8'hFF);                   // bytes other than the start byte
        send_byte(8'h00);                   // are dropped while idle
        send_byte(C_START_BYTE);            // start byte inside the payload,
        send_byte(8'd3);                    // a tick in mid frame, odd first
        send_byte(C_START_BYTE);
        send_item(C_FUNC_TICK, 8'hFF);
        send_byte(8'h80);
        send_byte(8'hFF);

        // Zero timeout: a single tick between bytes drops the frame, both in
        // the payload and while the length is still awaited.
        set_timeout(16'h0000);
        send_byte(C_START_BYTE);
        send_byte(8'd3);
        send_byte(8'h10);
        send_item(C_FUNC_TICK, 8'h00);
        send_byte(8'h20);
        send_byte(C_START_BYTE);
        send_item(C_FUNC_TICK, 8'h00);
        send_byte(8'h05);

        // Phase one: a gap before 6% of items, receiver stalls 57% of cycles.
        set_timeout(16'd4);
        run_random(300);

        // Phase two: the other way round.
        tx_gap_pct   = 57;
        rx_stall_pct = 6;
        set_timeout(16'h0000);
        run_random(150);
        set_timeout(16'd9);
        run_random(150);

        // Phase three: no idling on either side.
        tx_gap_pct   = 0;
        rx_stall_pct = 0;

        // Timeout boundary: exactly the timeout is allowed, one tick more
        // drops the frame and the next byte is ignored.
        set_timeout(16'd5);
        send_byte(C_START_BYTE);
        send_byte(8'd2);
        send_byte(8'h42);
        send_ticks(5);
        send_byte(8'h43);
        send_byte(C_START_BYTE);
        send_byte(8'd2);
        send_byte(8'h44);
        send_ticks(6);
        send_byte(8'h45);

        // Back-pressure: the receiver holds off while a long frame is offered,
        // so the pipeline fills and the input channel stalls.
        hold_request = 100;
        send_frame(40, 0);

        // Longest frame, and a frame whose length byte is the start byte.
        send_frame(255, 0);
        send_frame(int'(C_START_BYTE), 0);

        set_timeout(16'($urandom_range(1, 12)));
        run_random(300);

        // Wait for every expected result, then for DRAIN_CYCLES more to catch
        // any result that the block should not have produced.
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items over %0d timeout settings: %0d frames closed,",
                 items_sent, timeout_settings, sb.frames_closed);
        $display("%0d of them stored calls, %0d dropped on timeout; %0d results checked.",
                 sb.stored_calls, sb.frames_timed_out, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("length_framed_serial_deframer_unit test passed");
        end else begin
            $display("length_framed_serial_deframer_unit test failed");
        end
        $finish;
    end

endmodule

@@ length_framed_serial_deframer_unit.f @@
+incdir+hdl
hdl/lfsd_pkg.sv
hdl/lfsd_in_reg.sv
hdl/lfsd_core.sv
hdl/lfsd_out_reg.sv
hdl/length_framed_serial_deframer_unit.sv
hdl/lfsd_checker.sv
tb/deframe_check_pkg.sv
tb/tb_top.sv
